// File: src/kvt_pkg.sv
// Package for the keyed value table: sizes, opcodes, status codes,
// controller states and the transfer and command/status struct types.
// No dependencies.
package kvt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int FIELD_BITS  = 6;
    localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;

    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_ERASE  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_LOOKUP = 3'd3;
    localparam logic [OP_BITS-1:0] OP_COUNT  = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_DUP       = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_SHIFT,
        S_FINISH
    } kvt_state_t;

    typedef struct packed {
        logic [OP_BITS-1:0]    opcode;
        logic [KEY_BITS-1:0]   key_in;
        logic [VALUE_BITS-1:0] value_in;
    } kvt_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  value_out;
        logic [FIELD_BITS-1:0]  match_count;
        logic [FIELD_BITS-1:0]  fill;
    } kvt_rsp_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
        logic shift;
        logic finish;
    } kvt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic need_shift;
        logic shift_done;
        logic out_free;
    } kvt_sts_t;

endpackage

// File: src/kvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/kvt_ctrl.sv
// Controller state machine of the keyed value table.
// Depends on kvt_pkg; drives commands to kvt_dp and reads its status.
module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  kvt_sts_t sts,
    output kvt_cmd_t cmd
);

    kvt_state_t state_reg;
    kvt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = sts.need_shift ? S_SHIFT : S_FINISH;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/kvt_dp.sv
// Datapath of the keyed value table: entry memory, fill counter, search
// and compaction pointers, and the result register.
// Depends on kvt_pkg and kvt_ram; commanded by kvt_ctrl.
module kvt_dp
    import kvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  kvt_req_t req,
    input  kvt_cmd_t cmd,
    output kvt_sts_t sts,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output kvt_rsp_t rsp
);

    kvt_req_t                req_reg;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]     rd_idx_reg, rd_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [IDX_BITS-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                    found_reg, found_next;
    logic [IDX_BITS-1:0]     hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0]   hit_val_reg, hit_val_next;
    logic [CNT_BITS-1:0]     match_reg, match_next;
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    kvt_rsp_t                out_reg, out_next;
    logic                    out_vld_reg, out_vld_next;

    logic                    ram_we;
    logic [IDX_BITS-1:0]     ram_waddr;
    logic [ENTRY_BITS-1:0]   ram_wdata;
    logic                    ram_re;
    logic [ENTRY_BITS-1:0]   ram_rdata;
    logic [KEY_BITS-1:0]     q_key;
    logic [VALUE_BITS-1:0]   q_val;

    logic                    key_op;
    logic                    scan_op;
    logic                    key_hit;
    logic                    more;
    logic                    table_full;

    kvt_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign q_key = ram_rdata[ENTRY_BITS-1:VALUE_BITS];
    assign q_val = ram_rdata[VALUE_BITS-1:0];

    assign key_op     = (req_reg.opcode == OP_INSERT) || (req_reg.opcode == OP_ERASE)
                        || (req_reg.opcode == OP_LOOKUP);
    assign scan_op    = key_op || (req_reg.opcode == OP_COUNT);
    assign key_hit    = cmp_vld_reg && key_op && !found_reg && (q_key == req_reg.key_in);
    assign more       = (rd_idx_reg != cnt_reg);
    assign table_full = (cnt_reg == CNT_BITS'(TABLE_DEPTH));

    assign sts.scan_done  = !cmp_vld_reg && (found_reg || !more || !scan_op);
    assign sts.need_shift = (req_reg.opcode == OP_ERASE) && found_reg;
    assign sts.shift_done = !cmp_vld_reg && !more;
    assign sts.out_free   = !out_vld_reg || !rsp_stall;

    always_comb
    begin
        cnt_next     = cnt_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        hit_val_next = hit_val_reg;
        match_next   = match_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && rsp_stall;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[IDX_BITS-1:0];
        ram_wdata    = {req_reg.key_in, req_reg.value_in};
        ram_re       = 1'b0;

        if (cmd.load)
        begin
            rd_idx_next = '0;
            found_next  = 1'b0;
            match_next  = '0;
            status_next = ST_OK;
        end

        if (cmd.scan)
        begin
            if (key_hit)
            begin
                found_next   = 1'b1;
                hit_idx_next = cmp_idx_reg;
                hit_val_next = q_val;
            end
            if (cmp_vld_reg && (req_reg.opcode == OP_COUNT) && (q_val == req_reg.value_in))
            begin
                match_next = match_reg + CNT_BITS'(1);
            end
            if (scan_op && !found_reg && !key_hit && more)
            begin
                ram_re       = 1'b1;
                rd_idx_next  = rd_idx_reg + CNT_BITS'(1);
                cmp_vld_next = 1'b1;
                cmp_idx_next = rd_idx_reg[IDX_BITS-1:0];
            end
        end

        if (cmd.resolve)
        begin
            case (req_reg.opcode)
                OP_CLEAR:
                begin
                    cnt_next = '0;
                end
                OP_INSERT:
                begin
                    if (found_reg)
                    begin
                        status_next = ST_DUP;
                    end
                    else if (table_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_BITS'(1);
                    end
                end
                OP_ERASE:
                begin
                    if (found_reg)
                    begin
                        rd_idx_next = CNT_BITS'(hit_idx_reg) + CNT_BITS'(1);
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                OP_LOOKUP:
                begin
                    if (!found_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        if (cmd.shift)
        begin
            if (cmp_vld_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = cmp_idx_reg - IDX_BITS'(1);
                ram_wdata = ram_rdata;
            end
            if (more)
            begin
                ram_re       = 1'b1;
                rd_idx_next  = rd_idx_reg + CNT_BITS'(1);
                cmp_vld_next = 1'b1;
                cmp_idx_next = rd_idx_reg[IDX_BITS-1:0];
            end
            else if (!cmp_vld_reg)
            begin
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
        end

        if (cmd.finish)
        begin
            out_next.status      = status_reg;
            out_next.value_out   = ((req_reg.opcode == OP_LOOKUP) && found_reg)
                                   ? hit_val_reg : '0;
            out_next.match_count = (req_reg.opcode == OP_COUNT)
                                   ? FIELD_BITS'(match_reg) : '0;
            out_next.fill        = FIELD_BITS'(cnt_reg);
            out_vld_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            match_reg   <= '0;
            status_reg  <= ST_OK;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            match_reg   <= match_next;
            status_reg  <= status_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_val_reg <= hit_val_next;
        out_reg     <= out_next;
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("fill count exceeds the table depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (CNT_BITS'(cmp_idx_reg) < cnt_reg))
        else $error("entry read beyond the stored entries");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (rsp_valid && (rsp.fill == FIELD_BITS'(cnt_reg))))
        else $error("result not presented after finish");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.resolve && (req_reg.opcode == OP_INSERT) && !found_reg && !table_full)
        |=> (cnt_reg == $past(cnt_reg) + CNT_BITS'(1)))
        else $error("insert did not grow the table");

endmodule

// File: src/keyed_value_table.sv
// Keyed value table: key/value pairs searched linearly. Uses kvt_pkg, kvt_ctrl and kvt_dp.
// A keyed or count request scans the stored entries in order, a key op stopping at its hit,
// is resolved, and an erase that hits then shifts the later entries down one slot first.
// One request at a time: the next transfer is taken once the controller is back in idle after
// the result is registered, later while a stalled result holds the output. Reset clears the
// fill count and the control state; the entry memory is not cleared and needs no clearing pass.
module keyed_value_table
    import kvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  kvt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output kvt_rsp_t rsp
);

    kvt_cmd_t cmd;
    kvt_sts_t sts;

    kvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    kvt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
